// ===== rtl/rtcseq_pkg.sv =====
`timescale 1ns / 1ps

package rtcseq_pkg;

   // Sequencer phases
   typedef enum logic [4:0] {
      PH_IDLE, PH_W_START, PH_W_START_ACK, PH_W_DEV, PH_W_DEV_ACK, PH_W_REG,
      PH_W_REG_ACK, PH_W_DATA, PH_W_DATA_ACK, PH_STOP, PH_R_START,
      PH_R_START_ACK, PH_R_DEV, PH_R_DEV_ACK, PH_R_REG, PH_R_REG_ACK,
      PH_R_RSTART, PH_R_RSTART_ACK, PH_R_RDEV, PH_R_RDEV_ACK, PH_R_DATA,
      PH_R_DATA_ACK
   } phase_type;

   // Bus master commands
   typedef enum logic [2:0] {
      CMD_NONE      = 3'd0,
      CMD_START     = 3'd1,
      CMD_SEND      = 3'd2,
      CMD_READ_ACK  = 3'd3,
      CMD_READ_NACK = 3'd4,
      CMD_STOP      = 3'd5
   } cmd_type;

   // Request action codes
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // Configuration register indexes
   localparam logic REG_ENABLED = 1'b0;
   localparam logic REG_ADDRESS = 1'b1;

   // Bus master status codes
   localparam logic [7:0] ST_BUSY       = 8'h00;
   localparam logic [7:0] ST_START      = 8'h08;
   localparam logic [7:0] ST_RSTART     = 8'h10;
   localparam logic [7:0] ST_ADDR_W_ACK = 8'h18;
   localparam logic [7:0] ST_DATA_ACK   = 8'h28;
   localparam logic [7:0] ST_ADDR_R_ACK = 8'h40;
   localparam logic [7:0] ST_RX_ACK     = 8'h50;
   localparam logic [7:0] ST_RX_NACK    = 8'h58;

   localparam int           NumFields    = 7;
   localparam logic [2:0]   WeekdayIndex = 3'd3;
   localparam logic [2:0]   LastIndex    = 3'd6;
   localparam logic [6:0]   ResetAddress = 7'd104;
   localparam logic [7:0]   MaxValue     = 8'd99;

   typedef logic [7:0] field_array_type [NumFields];

   typedef struct packed {
      logic       enabled;
      logic [6:0] slave_address;
   } cfg_type;

   typedef struct packed {
      logic [1:0] action;
      logic       bus_free;
      logic [7:0] bus_status;
      logic [7:0] rx_byte;
      logic [6:0] new_second;
      logic [6:0] new_minute;
      logic [6:0] new_hour;
      logic [7:0] new_weekday;
      logic [6:0] new_day;
      logic [6:0] new_month;
      logic [6:0] new_year;
   } req_type;

   typedef struct packed {
      logic       accepted;
      cmd_type    command;
      logic [7:0] tx_byte;
   } step_type;

   // Clamp a seven-bit binary value to 99
   function automatic logic [7:0] clamp99(input logic [6:0] v);
      logic [7:0] w;
      begin
         w = {1'b0, v};
         clamp99 = (w > MaxValue) ? MaxValue : w;
      end
   endfunction

   // Binary to BCD; tens by reciprocal multiply, exact below 160
   function automatic logic [7:0] to_bcd(input logic [7:0] v);
      logic [15:0] prod;
      logic [3:0]  tens;
      logic [7:0]  ones;
      begin
         prod = {8'd0, v} * 16'd205;
         tens = prod[14:11];
         ones = v - ({1'b0, tens, 3'b000} + {3'b000, tens, 1'b0});
         to_bcd = {tens, ones[3:0]};
      end
   endfunction

   // BCD to binary; nibbles are not checked
   function automatic logic [7:0] from_bcd(input logic [7:0] b);
      begin
         from_bcd = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
      end
   endfunction

endpackage

// ===== rtl/rtcseq_step.sv =====
`timescale 1ns / 1ps

module rtcseq_step (
   input  rtcseq_pkg::cfg_type         cfg,
   input  rtcseq_pkg::req_type         req,
   input  rtcseq_pkg::phase_type       phase,
   input  logic [2:0]                  byte_index,
   input  rtcseq_pkg::field_array_type fields,
   input  logic                        ready_flag,
   output rtcseq_pkg::phase_type       phase_in,
   output logic [2:0]                  byte_index_in,
   output rtcseq_pkg::field_array_type fields_in,
   output logic                        ready_flag_in,
   output rtcseq_pkg::step_type        step
);

   logic [7:0] waddr;
   logic [7:0] st;
   logic       st_busy;
   logic       rx_ok;
   logic       is_request;
   logic       is_tick;
   logic       take_request;

   assign waddr   = {cfg.slave_address, 1'b0};
   assign st      = req.bus_status;
   assign st_busy = (st == rtcseq_pkg::ST_BUSY);
   assign rx_ok   = (st == rtcseq_pkg::ST_RX_NACK) || (st == rtcseq_pkg::ST_RX_ACK);

   // Classify the request and check whether a write or read can start
   assign is_request   = (req.action == rtcseq_pkg::ACT_WRITE) ||
                         (req.action == rtcseq_pkg::ACT_READ);
   assign is_tick      = (req.action == rtcseq_pkg::ACT_TICK) && cfg.enabled;
   assign take_request = is_request && cfg.enabled &&
                         (phase == rtcseq_pkg::PH_IDLE) && req.bus_free;

   // Advance on the expected status, hold while busy, drop to idle otherwise
   function automatic rtcseq_pkg::phase_type await_st(
      input logic [7:0] s, input logic [7:0] want,
      input rtcseq_pkg::phase_type cur, input rtcseq_pkg::phase_type nxt);
      begin
         if (s == rtcseq_pkg::ST_BUSY) await_st = cur;
         else if (s == want)           await_st = nxt;
         else                          await_st = rtcseq_pkg::PH_IDLE;
      end
   endfunction

   // Next state for one request
   always_comb begin
      phase_in      = phase;
      byte_index_in = byte_index;
      fields_in     = fields;
      ready_flag_in = ready_flag;

      if (take_request) begin
         byte_index_in = 3'd0;
         if (req.action == rtcseq_pkg::ACT_WRITE) begin
            fields_in[0] = rtcseq_pkg::clamp99(req.new_second);
            fields_in[1] = rtcseq_pkg::clamp99(req.new_minute);
            fields_in[2] = rtcseq_pkg::clamp99(req.new_hour);
            fields_in[3] = req.new_weekday;
            fields_in[4] = rtcseq_pkg::clamp99(req.new_day);
            fields_in[5] = rtcseq_pkg::clamp99(req.new_month);
            fields_in[6] = rtcseq_pkg::clamp99(req.new_year);
            phase_in     = rtcseq_pkg::PH_W_START;
         end else begin
            ready_flag_in = 1'b0;
            phase_in      = rtcseq_pkg::PH_R_START;
         end
      end else if (is_tick) begin
         case (phase)
            rtcseq_pkg::PH_IDLE: begin
               phase_in = rtcseq_pkg::PH_IDLE;
            end
            rtcseq_pkg::PH_W_START: begin
               phase_in = rtcseq_pkg::PH_W_START_ACK;
            end
            rtcseq_pkg::PH_W_START_ACK: begin
               phase_in = await_st(st, rtcseq_pkg::ST_START, phase, rtcseq_pkg::PH_W_DEV);
            end
            rtcseq_pkg::PH_W_DEV: begin
               phase_in = rtcseq_pkg::PH_W_DEV_ACK;
            end
            rtcseq_pkg::PH_W_DEV_ACK: begin
               phase_in = await_st(st, rtcseq_pkg::ST_ADDR_W_ACK, phase, rtcseq_pkg::PH_W_REG);
            end
            rtcseq_pkg::PH_W_REG: begin
               phase_in = rtcseq_pkg::PH_W_REG_ACK;
            end
            rtcseq_pkg::PH_W_REG_ACK: begin
               phase_in = await_st(st, rtcseq_pkg::ST_DATA_ACK, phase, rtcseq_pkg::PH_W_DATA);
            end
            rtcseq_pkg::PH_W_DATA: begin
               phase_in = rtcseq_pkg::PH_W_DATA_ACK;
            end
            rtcseq_pkg::PH_W_DATA_ACK: begin
               if (!st_busy) begin
                  if (st == rtcseq_pkg::ST_DATA_ACK) begin
                     if (byte_index >= rtcseq_pkg::LastIndex) begin
                        phase_in = rtcseq_pkg::PH_STOP;
                     end else begin
                        byte_index_in = byte_index + 3'd1;
                        phase_in      = rtcseq_pkg::PH_W_DATA;
                     end
                  end else begin
                     phase_in = rtcseq_pkg::PH_IDLE;
                  end
               end
            end
            rtcseq_pkg::PH_STOP: begin
               phase_in = rtcseq_pkg::PH_IDLE;
            end
            rtcseq_pkg::PH_R_START: begin
               phase_in = rtcseq_pkg::PH_R_START_ACK;
            end
            rtcseq_pkg::PH_R_START_ACK: begin
               phase_in = await_st(st, rtcseq_pkg::ST_START, phase, rtcseq_pkg::PH_R_DEV);
            end
            rtcseq_pkg::PH_R_DEV: begin
               phase_in = rtcseq_pkg::PH_R_DEV_ACK;
            end
            rtcseq_pkg::PH_R_DEV_ACK: begin
               phase_in = await_st(st, rtcseq_pkg::ST_ADDR_W_ACK, phase, rtcseq_pkg::PH_R_REG);
            end
            rtcseq_pkg::PH_R_REG: begin
               phase_in = rtcseq_pkg::PH_R_REG_ACK;
            end
            rtcseq_pkg::PH_R_REG_ACK: begin
               phase_in = await_st(st, rtcseq_pkg::ST_DATA_ACK, phase, rtcseq_pkg::PH_R_RSTART);
            end
            rtcseq_pkg::PH_R_RSTART: begin
               phase_in = rtcseq_pkg::PH_R_RSTART_ACK;
            end
            rtcseq_pkg::PH_R_RSTART_ACK: begin
               phase_in = await_st(st, rtcseq_pkg::ST_RSTART, phase, rtcseq_pkg::PH_R_RDEV);
            end
            rtcseq_pkg::PH_R_RDEV: begin
               phase_in = rtcseq_pkg::PH_R_RDEV_ACK;
            end
            rtcseq_pkg::PH_R_RDEV_ACK: begin
               phase_in = await_st(st, rtcseq_pkg::ST_ADDR_R_ACK, phase, rtcseq_pkg::PH_R_DATA);
            end
            rtcseq_pkg::PH_R_DATA: begin
               phase_in = rtcseq_pkg::PH_R_DATA_ACK;
            end
            rtcseq_pkg::PH_R_DATA_ACK: begin
               if (!st_busy) begin
                  if (rx_ok) begin
                     if (byte_index <= rtcseq_pkg::LastIndex) begin
                        if (byte_index == rtcseq_pkg::WeekdayIndex)
                           fields_in[byte_index] = req.rx_byte;
                        else
                           fields_in[byte_index] = rtcseq_pkg::from_bcd(req.rx_byte);
                     end
                     if (byte_index < rtcseq_pkg::LastIndex) begin
                        byte_index_in = byte_index + 3'd1;
                        phase_in      = rtcseq_pkg::PH_R_DATA;
                     end else begin
                        phase_in      = rtcseq_pkg::PH_STOP;
                        ready_flag_in = 1'b1;
                     end
                  end else begin
                     phase_in = rtcseq_pkg::PH_IDLE;
                  end
               end
            end
            default: begin
               phase_in = rtcseq_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // Bus command, byte to send and request acknowledge
   always_comb begin
      step          = '0;
      step.command  = rtcseq_pkg::CMD_NONE;
      step.accepted = take_request;

      if (is_tick) begin
         case (phase)
            rtcseq_pkg::PH_W_START, rtcseq_pkg::PH_R_START,
            rtcseq_pkg::PH_R_RSTART: begin
               step.command = rtcseq_pkg::CMD_START;
            end
            rtcseq_pkg::PH_W_DEV, rtcseq_pkg::PH_R_DEV: begin
               step.command = rtcseq_pkg::CMD_SEND;
               step.tx_byte = waddr;
            end
            rtcseq_pkg::PH_W_REG, rtcseq_pkg::PH_R_REG: begin
               step.command = rtcseq_pkg::CMD_SEND;
            end
            rtcseq_pkg::PH_W_DATA: begin
               step.command = rtcseq_pkg::CMD_SEND;
               if (byte_index <= rtcseq_pkg::LastIndex) begin
                  if (byte_index == rtcseq_pkg::WeekdayIndex)
                     step.tx_byte = fields[byte_index];
                  else
                     step.tx_byte = rtcseq_pkg::to_bcd(fields[byte_index]);
               end
            end
            rtcseq_pkg::PH_STOP: begin
               step.command = rtcseq_pkg::CMD_STOP;
            end
            rtcseq_pkg::PH_R_RDEV: begin
               step.command = rtcseq_pkg::CMD_SEND;
               step.tx_byte = waddr | 8'h01;
            end
            rtcseq_pkg::PH_R_DATA: begin
               step.command = (byte_index < rtcseq_pkg::LastIndex) ?
                              rtcseq_pkg::CMD_READ_ACK : rtcseq_pkg::CMD_READ_NACK;
            end
            default: begin
               step.command = rtcseq_pkg::CMD_NONE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/rtc_i2c_datetime_sequencer_unit.sv =====
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// req       req_tvalid/req_tready  req_tuser action, req_tdata bus status, rx, time
// rsp       rsp_tvalid/rsp_tready  rsp_tdata one result per request
// csr       csr_valid/csr_ready    csr_index, csr_data register write
//
// One request per clock while req_tready is high; its result is registered.
// All work is one pass of the phase logic between the state and result registers.
// A two-slot output (result register plus skid register) absorbs rsp stalls;
// req_tready drops only while the skid slot is full.
// Reset is synchronous and clears state, configuration and valid flags.

module rtc_i2c_datetime_sequencer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action[1:0]
   input  logic [1:0]  req_tuser,
   // bus_free[0], bus_status[8:1], rx_byte[16:9], new_second[23:17],
   // new_minute[30:24], new_hour[37:31], new_weekday[45:38], new_day[52:46],
   // new_month[59:53], new_year[66:60], zero[71:67]
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // accepted[0], command[3:1], tx_byte[11:4], data_ready[12], busy_res[13],
   // got_second[21:14], got_minute[29:22], got_hour[37:30], got_weekday[45:38],
   // got_day[53:46], got_month[61:54], got_year[69:62], zero[71:70]
   output logic [71:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [6:0]  csr_data
);

   rtcseq_pkg::cfg_type         cfg_ff;
   rtcseq_pkg::phase_type       phase_ff, phase_in;
   logic [2:0]                  byte_index_ff, byte_index_in;
   rtcseq_pkg::field_array_type fields_ff, fields_in;
   logic                        ready_flag_ff, ready_flag_in;
   rtcseq_pkg::req_type         req;
   rtcseq_pkg::step_type        step;
   logic [71:0]                 result;
   logic [71:0]                 rsp_data_ff, skid_data_ff;
   logic                        rsp_valid_ff, skid_valid_ff;
   logic                        req_fire, slot_free;

   // Unpack request
   assign req.action      = req_tuser;
   assign req.bus_free    = req_tdata[0];
   assign req.bus_status  = req_tdata[8:1];
   assign req.rx_byte     = req_tdata[16:9];
   assign req.new_second  = req_tdata[23:17];
   assign req.new_minute  = req_tdata[30:24];
   assign req.new_hour    = req_tdata[37:31];
   assign req.new_weekday = req_tdata[45:38];
   assign req.new_day     = req_tdata[52:46];
   assign req.new_month   = req_tdata[59:53];
   assign req.new_year    = req_tdata[66:60];

   assign req_tready = !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   rtcseq_step u_step (
      .cfg           (cfg_ff),
      .req           (req),
      .phase         (phase_ff),
      .byte_index    (byte_index_ff),
      .fields        (fields_ff),
      .ready_flag    (ready_flag_ff),
      .phase_in      (phase_in),
      .byte_index_in (byte_index_in),
      .fields_in     (fields_in),
      .ready_flag_in (ready_flag_in),
      .step          (step)
   );

   // Pack result from the post-step state
   assign result = {2'b00, fields_in[6], fields_in[5], fields_in[4], fields_in[3],
                    fields_in[2], fields_in[1], fields_in[0],
                    (phase_in != rtcseq_pkg::PH_IDLE), ready_flag_in,
                    step.tx_byte, step.command, step.accepted};

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled       <= 1'b0;
         cfg_ff.slave_address <= rtcseq_pkg::ResetAddress;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rtcseq_pkg::REG_ENABLED: cfg_ff.enabled       <= csr_data[0];
            rtcseq_pkg::REG_ADDRESS: cfg_ff.slave_address <= csr_data;
            default:                 cfg_ff               <= cfg_ff;
         endcase
      end
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= rtcseq_pkg::PH_IDLE;
         byte_index_ff <= 3'd0;
         ready_flag_ff <= 1'b0;
         for (int i = 0; i < rtcseq_pkg::NumFields; i++) fields_ff[i] <= 8'd0;
      end else if (req_fire) begin
         phase_ff      <= phase_in;
         byte_index_ff <= byte_index_in;
         ready_flag_ff <= ready_flag_in;
         fields_ff     <= fields_in;
      end
   end

   // Output slot and skid slot valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (slot_free) begin
         rsp_valid_ff  <= skid_valid_ff || req_fire;
         skid_valid_ff <= 1'b0;
      end else if (req_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Output and skid payloads
   always_ff @(posedge clock) begin
      if (slot_free) begin
         if (skid_valid_ff) rsp_data_ff <= skid_data_ff;
         else if (req_fire) rsp_data_ff <= result;
      end else if (req_fire) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A filled skid slot always sits behind a filled output slot
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid slot valid while output slot empty");

   // After every accepted request the output slot holds a valid result in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted request produced no result");

   // A taken request leaves the sequencer busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[0]) |-> rsp_data_ff[13])
      else $error("request taken but sequencer reports idle");

   // A stall with a full skid slot holds the output
   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_tready) |=> (rsp_valid_ff && skid_valid_ff))
      else $error("stalled output lost a result");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import rtcseq_pkg::*;

   // Action code with no meaning to the block
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int SinkHoldCycles = 300;

   typedef struct packed {
      logic             accepted;
      cmd_type          command;
      logic [7:0]       tx_byte;
      logic             data_ready;
      logic             busy;
      logic [6:0][7:0]  got;
   } seq_result_type;

   // One directed row: a register write or a request with its pinned result
   typedef struct packed {
      logic       is_csr;
      logic       csr_index;
      logic [6:0] csr_data;
      logic [1:0] action;
      logic       bus_free;
      logic [7:0] bus_status;
      logic [7:0] rx_byte;
      logic       accepted;
      cmd_type    command;
      logic [7:0] tx_byte;
      logic       busy;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;
   logic [71:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [6:0]  csr_data = '0;

   // Sequencer state as predicted from the accepted requests
   logic       cfg_enabled = 1'b0;
   logic [6:0] cfg_address = ResetAddress;
   phase_type  seq_phase = PH_IDLE;
   logic [2:0] seq_index = '0;
   logic [7:0] seq_fields [7] = '{default: 8'd0};
   logic       seq_ready = 1'b0;

   seq_result_type pending_results [$];
   plan_row_type   plan [$];
   int             mismatches = 0;
   int             source_gap_pct = 0;
   int             sink_gap_pct = 0;
   logic           hold_sink = 1'b0;

   string got_names [7] = '{"got_second", "got_minute", "got_hour", "got_weekday",
                            "got_day", "got_month", "got_year"};

   rtc_i2c_datetime_sequencer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic [7:0] clamp_time(input logic [6:0] v);
      return (v > 7'd99) ? 8'd99 : {1'b0, v};
   endfunction

   function automatic logic [7:0] bin_to_bcd(input logic [7:0] v);
      return {4'(v / 8'd10), 4'(v % 8'd10)};
   endfunction

   function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
      return 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
   endfunction

   // Hold on a busy status, advance on the awaited code, otherwise drop to idle
   function automatic phase_type after_status(input logic [7:0] st, input logic [7:0] want,
                                              input phase_type next_phase);
      if (st == ST_BUSY) return seq_phase;
      return (st == want) ? next_phase : PH_IDLE;
   endfunction

   // Advance the predicted sequencer by one request and return its result
   function automatic seq_result_type predict_sequencer_step(input req_type it);
      seq_result_type r;
      logic [7:0]     dev_byte;
      logic [7:0]     st;
      r = '0;
      r.command = CMD_NONE;
      dev_byte = {cfg_address, 1'b0};
      st = it.bus_status;
      if (it.action == ACT_WRITE || it.action == ACT_READ) begin
         if (cfg_enabled && seq_phase == PH_IDLE && it.bus_free) begin
            r.accepted = 1'b1;
            seq_index = '0;
            if (it.action == ACT_WRITE) begin
               seq_fields[0] = clamp_time(it.new_second);
               seq_fields[1] = clamp_time(it.new_minute);
               seq_fields[2] = clamp_time(it.new_hour);
               seq_fields[3] = it.new_weekday;
               seq_fields[4] = clamp_time(it.new_day);
               seq_fields[5] = clamp_time(it.new_month);
               seq_fields[6] = clamp_time(it.new_year);
               seq_phase = PH_W_START;
            end else begin
               seq_ready = 1'b0;
               seq_phase = PH_R_START;
            end
         end
      end else if (it.action == ACT_TICK && cfg_enabled) begin
         case (seq_phase)
            PH_W_START: begin
               r.command = CMD_START;
               seq_phase = PH_W_START_ACK;
            end
            PH_W_START_ACK: seq_phase = after_status(st, ST_START, PH_W_DEV);
            PH_W_DEV: begin
               r.command = CMD_SEND;
               r.tx_byte = dev_byte;
               seq_phase = PH_W_DEV_ACK;
            end
            PH_W_DEV_ACK: seq_phase = after_status(st, ST_ADDR_W_ACK, PH_W_REG);
            PH_W_REG: begin
               r.command = CMD_SEND;
               seq_phase = PH_W_REG_ACK;
            end
            PH_W_REG_ACK: seq_phase = after_status(st, ST_DATA_ACK, PH_W_DATA);
            PH_W_DATA: begin
               // weekday goes out raw, everything else as BCD
               r.command = CMD_SEND;
               r.tx_byte = (seq_index == WeekdayIndex) ? seq_fields[seq_index]
                                                       : bin_to_bcd(seq_fields[seq_index]);
               seq_phase = PH_W_DATA_ACK;
            end
            PH_W_DATA_ACK: begin
               if (st == ST_DATA_ACK) begin
                  if (seq_index >= LastIndex) begin
                     seq_phase = PH_STOP;
                  end else begin
                     seq_index = seq_index + 3'd1;
                     seq_phase = PH_W_DATA;
                  end
               end else if (st != ST_BUSY) begin
                  seq_phase = PH_IDLE;
               end
            end
            PH_STOP: begin
               r.command = CMD_STOP;
               seq_phase = PH_IDLE;
            end
            PH_R_START: begin
               r.command = CMD_START;
               seq_phase = PH_R_START_ACK;
            end
            PH_R_START_ACK: seq_phase = after_status(st, ST_START, PH_R_DEV);
            PH_R_DEV: begin
               r.command = CMD_SEND;
               r.tx_byte = dev_byte;
               seq_phase = PH_R_DEV_ACK;
            end
            PH_R_DEV_ACK: seq_phase = after_status(st, ST_ADDR_W_ACK, PH_R_REG);
            PH_R_REG: begin
               r.command = CMD_SEND;
               seq_phase = PH_R_REG_ACK;
            end
            PH_R_REG_ACK: seq_phase = after_status(st, ST_DATA_ACK, PH_R_RSTART);
            PH_R_RSTART: begin
               r.command = CMD_START;
               seq_phase = PH_R_RSTART_ACK;
            end
            PH_R_RSTART_ACK: seq_phase = after_status(st, ST_RSTART, PH_R_RDEV);
            PH_R_RDEV: begin
               r.command = CMD_SEND;
               r.tx_byte = dev_byte | 8'h01;
               seq_phase = PH_R_RDEV_ACK;
            end
            PH_R_RDEV_ACK: seq_phase = after_status(st, ST_ADDR_R_ACK, PH_R_DATA);
            PH_R_DATA: begin
               r.command = (seq_index < LastIndex) ? CMD_READ_ACK : CMD_READ_NACK;
               seq_phase = PH_R_DATA_ACK;
            end
            PH_R_DATA_ACK: begin
               // either receive status counts for every byte
               if (st == ST_RX_ACK || st == ST_RX_NACK) begin
                  seq_fields[seq_index] = (seq_index == WeekdayIndex) ? it.rx_byte
                                                                      : bcd_to_bin(it.rx_byte);
                  if (seq_index < LastIndex) begin
                     seq_index = seq_index + 3'd1;
                     seq_phase = PH_R_DATA;
                  end else begin
                     seq_phase = PH_STOP;
                     seq_ready = 1'b1;
                  end
               end else if (st != ST_BUSY) begin
                  seq_phase = PH_IDLE;
               end
            end
            default: seq_phase = PH_IDLE;
         endcase
      end
      r.data_ready = seq_ready;
      r.busy = (seq_phase != PH_IDLE);
      for (int k = 0; k < 7; k++) r.got[k] = seq_fields[k];
      return r;
   endfunction

   // Status a well-behaved bus master would report in the given phase
   function automatic logic [7:0] awaited_status(input phase_type p);
      case (p)
         PH_W_START_ACK, PH_R_START_ACK: return ST_START;
         PH_W_DEV_ACK, PH_R_DEV_ACK: return ST_ADDR_W_ACK;
         PH_W_REG_ACK, PH_R_REG_ACK, PH_W_DATA_ACK: return ST_DATA_ACK;
         PH_R_RSTART_ACK: return ST_RSTART;
         PH_R_RDEV_ACK: return ST_ADDR_R_ACK;
         PH_R_DATA_ACK: return ($urandom_range(1) != 0) ? ST_RX_ACK : ST_RX_NACK;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Mostly in range, sometimes above 99 to hit the clamp
   function automatic logic [6:0] random_time_value();
      return ($urandom_range(9) < 7) ? 7'($urandom_range(99)) : 7'($urandom_range(127));
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned seen);
      if (want != seen) begin
         $error("%s: expected %0d, got %0d", name, want, seen);
         mismatches++;
      end
   endtask

   // Offer one request, wait for it to be taken, then record its expected result
   task automatic send_request(input req_type it, input logic pinned,
                               input seq_result_type pin);
      seq_result_type want;
      csr_valid <= 1'b0;
      if ($urandom_range(99) < source_gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < source_gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.action;
      req_tdata <= {5'b0, it.new_year, it.new_month, it.new_day, it.new_weekday,
                    it.new_hour, it.new_minute, it.new_second, it.rx_byte,
                    it.bus_status, it.bus_free};
      do @(posedge clock); while (!req_tready);
      want = predict_sequencer_step(it);
      if (pinned) begin
         want.accepted = pin.accepted;
         want.command = pin.command;
         want.tx_byte = pin.tx_byte;
         want.busy = pin.busy;
      end
      pending_results.push_back(want);
   endtask

   // Write a register once every outstanding result has come back
   task automatic write_register(input logic idx, input logic [6:0] value);
      req_tvalid <= 1'b0;
      csr_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_ENABLED) cfg_enabled = value[0];
      else cfg_address = value;
   endtask

   // Mostly well-formed transactions with random content, some noise on top
   task automatic make_random_item(input logic settle, output req_type it);
      int pick;
      pick = $urandom_range(99);
      it.action = ACT_TICK;
      it.bus_free = ($urandom_range(9) != 0);
      it.bus_status = 8'($urandom_range(255));
      it.rx_byte = 8'($urandom_range(255));
      it.new_second = random_time_value();
      it.new_minute = random_time_value();
      it.new_hour = random_time_value();
      it.new_weekday = 8'($urandom_range(255));
      it.new_day = random_time_value();
      it.new_month = random_time_value();
      it.new_year = random_time_value();
      if (settle) begin
         it.bus_status = awaited_status(seq_phase);
      end else if (seq_phase == PH_IDLE) begin
         if (pick < 45) it.action = ACT_WRITE;
         else if (pick < 88) it.action = ACT_READ;
         else it.action = 2'($urandom_range(3));
      end else if (pick < 90) begin
         it.bus_status = (pick < 14) ? ST_BUSY : awaited_status(seq_phase);
      end else if (pick < 97) begin
         it.action = 2'($urandom_range(3));
      end
   endtask

   // Run a batch of random requests, then finish the open transaction
   task automatic run_random(input int count);
      req_type        it;
      seq_result_type no_pin;
      no_pin = '0;
      for (int n = 0; n < count || seq_phase != PH_IDLE; n++) begin
         make_random_item(n >= count, it);
         send_request(it, 1'b0, no_pin);
      end
   endtask

   // Receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_sink) begin
            rsp_tready <= 1'b0;
            repeat (SinkHoldCycles) @(posedge clock);
            hold_sink = 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= sink_gap_pct);
      end
   end

   // Compare each returned result with the oldest expectation
   always @(posedge clock) begin : check_results
      seq_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result returned with no request waiting for it");
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("accepted", want.accepted, rsp_tdata[0]);
            check_field("command", want.command, rsp_tdata[3:1]);
            check_field("tx_byte", want.tx_byte, rsp_tdata[11:4]);
            check_field("data_ready", want.data_ready, rsp_tdata[12]);
            check_field("busy_res", want.busy, rsp_tdata[13]);
            for (int k = 0; k < 7; k++) begin
               check_field(got_names[k], want.got[k], rsp_tdata[14 + 8 * k +: 8]);
            end
         end
      end
   end

   initial begin : stimulus
      req_type        item;
      seq_result_type pin;
      int             drain;

      // Disabled after reset: ticks and requests do nothing
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_TICK, 1'b1, ST_START, 8'h00,
                       1'b0, CMD_NONE, 8'h00, 1'b0});
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_WRITE, 1'b1, ST_BUSY, 8'h00,
                       1'b0, CMD_NONE, 8'h00, 1'b0});
      plan.push_back('{1'b1, REG_ENABLED, 7'd1, ACT_TICK, 1'b0, ST_BUSY, 8'h00,
                       1'b0, CMD_NONE, 8'h00, 1'b0});
      plan.push_back('{1'b1, REG_ADDRESS, 7'h7F, ACT_TICK, 1'b0, ST_BUSY, 8'h00,
                       1'b0, CMD_NONE, 8'h00, 1'b0});
      // Bus not free refuses; then a write with clamped and raw fields
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_WRITE, 1'b0, ST_BUSY, 8'h00,
                       1'b0, CMD_NONE, 8'h00, 1'b0});
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_WRITE, 1'b1, ST_BUSY, 8'h00,
                       1'b1, CMD_NONE, 8'h00, 1'b1});
      // Request while busy is refused, unused action is a no-op
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_READ, 1'b1, ST_BUSY, 8'h00,
                       1'b0, CMD_NONE, 8'h00, 1'b1});
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_UNUSED, 1'b1, 8'hFF, 8'hFF,
                       1'b0, CMD_NONE, 8'h00, 1'b1});
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_TICK, 1'b1, 8'hFF, 8'h00,
                       1'b0, CMD_START, 8'h00, 1'b1});
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_TICK, 1'b1, ST_BUSY, 8'h00,
                       1'b0, CMD_NONE, 8'h00, 1'b1});
      // Unexpected status drops to idle with no stop
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_TICK, 1'b1, 8'hFF, 8'h00,
                       1'b0, CMD_NONE, 8'h00, 1'b0});
      plan.push_back('{1'b1, REG_ADDRESS, 7'h00, ACT_TICK, 1'b0, ST_BUSY, 8'h00,
                       1'b0, CMD_NONE, 8'h00, 1'b0});
      // Read through pointer write, repeated start and read address
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_READ, 1'b1, ST_BUSY, 8'h00,
                       1'b1, CMD_NONE, 8'h00, 1'b1});
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_TICK, 1'b1, ST_BUSY, 8'h00,
                       1'b0, CMD_START, 8'h00, 1'b1});
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_TICK, 1'b1, ST_START, 8'h00,
                       1'b0, CMD_NONE, 8'h00, 1'b1});
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_TICK, 1'b1, ST_BUSY, 8'h00,
                       1'b0, CMD_SEND, 8'h00, 1'b1});
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_TICK, 1'b1, ST_ADDR_W_ACK, 8'h00,
                       1'b0, CMD_NONE, 8'h00, 1'b1});
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_TICK, 1'b1, ST_BUSY, 8'h00,
                       1'b0, CMD_SEND, 8'h00, 1'b1});
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_TICK, 1'b1, ST_DATA_ACK, 8'h00,
                       1'b0, CMD_NONE, 8'h00, 1'b1});
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_TICK, 1'b1, ST_BUSY, 8'h00,
                       1'b0, CMD_START, 8'h00, 1'b1});
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_TICK, 1'b1, ST_RSTART, 8'h00,
                       1'b0, CMD_NONE, 8'h00, 1'b1});
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_TICK, 1'b1, ST_BUSY, 8'h00,
                       1'b0, CMD_SEND, 8'h01, 1'b1});
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_TICK, 1'b1, ST_ADDR_R_ACK, 8'h00,
                       1'b0, CMD_NONE, 8'h00, 1'b1});
      // Both receive statuses take a byte, a wrong one aborts the read
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_TICK, 1'b1, ST_BUSY, 8'h00,
                       1'b0, CMD_READ_ACK, 8'h00, 1'b1});
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_TICK, 1'b1, ST_RX_ACK, 8'h99,
                       1'b0, CMD_NONE, 8'h00, 1'b1});
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_TICK, 1'b1, ST_BUSY, 8'h00,
                       1'b0, CMD_READ_ACK, 8'h00, 1'b1});
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_TICK, 1'b1, ST_RX_NACK, 8'hFF,
                       1'b0, CMD_NONE, 8'h00, 1'b1});
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_TICK, 1'b1, ST_BUSY, 8'h00,
                       1'b0, CMD_READ_ACK, 8'h00, 1'b1});
      plan.push_back('{1'b0, REG_ENABLED, 7'd0, ACT_TICK, 1'b1, ST_DATA_ACK, 8'h00,
                       1'b0, CMD_NONE, 8'h00, 1'b0});

      item = '0;
      item.new_second = 7'd127;
      item.new_minute = 7'd0;
      item.new_hour = 7'd99;
      item.new_weekday = 8'hFF;
      item.new_day = 7'd100;
      item.new_month = 7'd1;
      item.new_year = 7'd59;

      source_gap_pct = 16;
      sink_gap_pct = 82;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed rows
      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            write_register(plan[i].csr_index, plan[i].csr_data);
         end else begin
            item.action = plan[i].action;
            item.bus_free = plan[i].bus_free;
            item.bus_status = plan[i].bus_status;
            item.rx_byte = plan[i].rx_byte;
            pin = '0;
            pin.accepted = plan[i].accepted;
            pin.command = plan[i].command;
            pin.tx_byte = plan[i].tx_byte;
            pin.busy = plan[i].busy;
            send_request(item, 1'b1, pin);
         end
      end

      // Light source gaps, heavy receiver stalls
      write_register(REG_ADDRESS, 7'($urandom_range(127)));
      run_random(300);

      // Disabled stretch, then the top address
      write_register(REG_ENABLED, 7'd0);
      run_random(40);
      write_register(REG_ENABLED, 7'd1);
      write_register(REG_ADDRESS, 7'h7F);

      // Heavy source gaps, light receiver stalls
      source_gap_pct = 82;
      sink_gap_pct = 16;
      run_random(300);

      // Full rate, with one long receiver hold-off midway
      write_register(REG_ADDRESS, ResetAddress);
      source_gap_pct = 0;
      sink_gap_pct = 0;
      run_random(150);
      hold_sink = 1'b1;
      run_random(150);

      // Drain the outstanding results
      req_tvalid <= 1'b0;
      csr_valid <= 1'b0;
      drain = 0;
      while (pending_results.size() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (4) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/rtcseq_pkg.sv
rtl/rtcseq_step.sv
rtl/rtc_i2c_datetime_sequencer_unit.sv
sim/tb.sv
